@@ rtl/ddtc_pkg.sv @@
// Shared types, widths and constants of the differential drive turn controller.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ddtc_pkg;

  // Default encoder position width
  localparam int POS_WIDTH_DEF = 32;

  // Error path: values saturate to +-2^46, so 48 signed bits hold them
  localparam int ERR_W   = 48;
  localparam int EA_W    = ERR_W + 2;
  localparam logic signed [63:0] SAT_LIM = 64'sd1 <<< 46;

  // Scaling: magnitude times a 16-bit Q8.8 gain, drop eight fraction bits
  localparam int GAIN_W  = 16;
  localparam int MAG_W   = ERR_W - 1;
  localparam int PROD_W  = MAG_W + GAIN_W;
  localparam int TERM_W  = PROD_W - 8 + 1;

  // Speed fields
  localparam int SPEED_W = 16;
  localparam int LIMIT_W = 15;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd5;

  localparam logic [LIMIT_W-1:0] MAX_SPEED_RST = 15'd32767;
  localparam logic [15:0]        TOLERANCE_RST = 16'd100;

  // Input item kinds
  localparam logic MODE_START  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic signed [31:0]  target_ticks;
    logic [GAIN_W-1:0]   angle_gain;
    logic [GAIN_W-1:0]   sync_gain;
    logic [LIMIT_W-1:0]  min_speed;
    logic [LIMIT_W-1:0]  max_speed;
    logic [15:0]         tolerance;
  } cfg_t;

  // Result control carried down the pipeline
  typedef struct packed {
    logic zero;   // force both speeds to zero
    logic done;   // turn finished or no target
  } flag_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] angle_err;
    logic signed [ERR_W-1:0] sync_err;
    flag_t                   flags;
  } err_item_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] angle_term;
    logic signed [TERM_W-1:0] sync_term;
    flag_t                    flags;
  } term_item_t;

  // Saturate the angle error sum to +-2^46
  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [EA_W-1:0] x);
    logic signed [EA_W-1:0] hi;
    hi = EA_W'(SAT_LIM);
    if (x > hi) begin
      sat_err = ERR_W'(hi);
    end else if (x < -hi) begin
      sat_err = ERR_W'(-hi);
    end else begin
      sat_err = x[ERR_W-1:0];
    end
  endfunction

endpackage

@@ rtl/ddtc_err.sv @@
// Input register, start position latch and error stage of the turn controller.
// Depends on ddtc_pkg for the error widths and item types.
`timescale 1ns / 1ps

module ddtc_err #(
  parameter int POS_WIDTH = ddtc_pkg::POS_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ddtc_pkg::cfg_t          cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_mode,
  input  logic signed [POS_WIDTH-1:0] in_left,
  input  logic signed [POS_WIDTH-1:0] in_right,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ddtc_pkg::err_item_t     out_item
);
  import ddtc_pkg::*;

  localparam int WIDE_W = ((POS_WIDTH > ERR_W) ? POS_WIDTH : ERR_W) + 2;

  logic                        v1;
  logic                        mode1;
  logic signed [POS_WIDTH-1:0] lp1;
  logic signed [POS_WIDTH-1:0] rp1;
  logic signed [POS_WIDTH-1:0] left_start;
  logic signed [POS_WIDTH-1:0] right_start;

  logic                        adv1;
  logic signed [POS_WIDTH-1:0] dl_wrap;
  logic signed [POS_WIDTH-1:0] dr_wrap;
  logic signed [WIDE_W-1:0]    dl_wide;
  logic signed [WIDE_W-1:0]    dr_wide;
  logic signed [ERR_W-1:0]     dl;
  logic signed [ERR_W-1:0]     dr;
  logic signed [EA_W-1:0]      ea_raw;
  logic signed [EA_W-1:0]      es_raw;
  logic signed [ERR_W-1:0]     ea;
  logic signed [ERR_W-1:0]     es;
  logic [MAG_W-1:0]            ea_mag;
  logic                        target_zero;
  logic                        within_tol;
  err_item_t                   item_next;

  // Saturate a wide delta to +-2^46
  function automatic logic signed [ERR_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    hi = WIDE_W'(SAT_LIM);
    if (x > hi) begin
      sat_wide = ERR_W'(hi);
    end else if (x < -hi) begin
      sat_wide = ERR_W'(-hi);
    end else begin
      sat_wide = x[ERR_W-1:0];
    end
  endfunction

  // A stage takes a request when it is empty or its contents move on
  assign in_ready = !v1 || out_ready || !out_valid;
  assign adv1     = v1 && (out_ready || !out_valid);

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
    if (in_ready && in_valid) begin
      mode1 <= in_mode;
      lp1   <= in_left;
      rp1   <= in_right;
    end
  end

  // Latch start positions when a start request leaves this stage
  always_ff @(posedge clk) begin
    if (rst) begin
      left_start  <= '0;
      right_start <= '0;
    end else if (adv1 && (mode1 == MODE_START)) begin
      left_start  <= lp1;
      right_start <= rp1;
    end
  end

  // Wheel deltas modulo the position width, right delta negated
  always_comb begin
    dl_wrap = lp1 - left_start;
    dr_wrap = rp1 - right_start;
    dl_wide = {{(WIDE_W-POS_WIDTH){dl_wrap[POS_WIDTH-1]}}, dl_wrap};
    dr_wide = -{{(WIDE_W-POS_WIDTH){dr_wrap[POS_WIDTH-1]}}, dr_wrap};
    dl      = sat_wide(dl_wide);
    dr      = sat_wide(dr_wide);
  end

  // Angle and sync errors, tolerance check
  always_comb begin
    ea_raw = {{(EA_W-32){cfg.target_ticks[31]}}, cfg.target_ticks}
             - ({{2{dl[ERR_W-1]}}, dl} - {{2{dr[ERR_W-1]}}, dr});
    es_raw = {{2{dl[ERR_W-1]}}, dl} + {{2{dr[ERR_W-1]}}, dr};
    ea     = sat_err(ea_raw);
    es     = sat_err(es_raw);
    ea_mag = ea[ERR_W-1] ? MAG_W'(-ea) : ea[MAG_W-1:0];
    target_zero = (cfg.target_ticks == '0);
    within_tol  = (ea_mag < {{(MAG_W-16){1'b0}}, cfg.tolerance});

    item_next.angle_err  = ea;
    item_next.sync_err   = es;
    item_next.flags.zero = (mode1 == MODE_START) || target_zero || within_tol;
    item_next.flags.done = target_zero || ((mode1 == MODE_SAMPLE) && within_tol);
  end

  // Result register of this stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      out_valid <= v1;
    end
    if (adv1) begin
      out_item <= item_next;
    end
  end

  a_left_latch: assert property (@(posedge clk) disable iff (rst)
    (adv1 && (mode1 == MODE_START)) |=> (left_start == $past(lp1)))
    else $error("left start position not latched");

  a_right_latch: assert property (@(posedge clk) disable iff (rst)
    (adv1 && (mode1 == MODE_START)) |=> (right_start == $past(rp1)))
    else $error("right start position not latched");

  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    (adv1 && (mode1 == MODE_START)) |=> (out_valid && out_item.flags.zero))
    else $error("start request did not force zero speeds");

endmodule

@@ rtl/ddtc_scale.sv @@
// Gain stage: scales angle and sync errors by their Q8.8 gains.
// Depends on ddtc_pkg for the item types and product widths.
`timescale 1ns / 1ps

module ddtc_scale (
  input  logic                  clk,
  input  logic                  rst,
  input  ddtc_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ddtc_pkg::err_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ddtc_pkg::term_item_t  out_item
);
  import ddtc_pkg::*;

  logic                      adv;
  logic [MAG_W-1:0]          angle_mag;
  logic [MAG_W-1:0]          sync_mag;
  logic [PROD_W-1:0]         angle_prod;
  logic [PROD_W-1:0]         sync_prod;
  logic signed [TERM_W-1:0]  angle_pos;
  logic signed [TERM_W-1:0]  sync_pos;
  term_item_t                item_next;

  assign in_ready = out_ready || !out_valid;
  assign adv      = in_valid && in_ready;

  // Magnitude times gain, truncate toward zero, restore sign
  always_comb begin
    angle_mag  = in_item.angle_err[ERR_W-1] ? MAG_W'(-in_item.angle_err)
                                            : in_item.angle_err[MAG_W-1:0];
    sync_mag   = in_item.sync_err[ERR_W-1]  ? MAG_W'(-in_item.sync_err)
                                            : in_item.sync_err[MAG_W-1:0];
    angle_prod = PROD_W'(angle_mag) * PROD_W'(cfg.angle_gain);
    sync_prod  = PROD_W'(sync_mag)  * PROD_W'(cfg.sync_gain);
    angle_pos  = {1'b0, angle_prod[PROD_W-1:8]};
    sync_pos   = {1'b0, sync_prod[PROD_W-1:8]};

    item_next.angle_term = in_item.angle_err[ERR_W-1] ? -angle_pos : angle_pos;
    item_next.sync_term  = in_item.sync_err[ERR_W-1]  ? -sync_pos  : sync_pos;
    item_next.flags      = in_item.flags;
  end

  // Result register of this stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_item <= item_next;
    end
  end

endmodule

@@ rtl/ddtc_mix.sv @@
// Output stage: adds minimum speed, clamps both wheels and drives the result register.
// Depends on ddtc_pkg for the item types and speed widths.
`timescale 1ns / 1ps

module ddtc_mix (
  input  logic                  clk,
  input  logic                  rst,
  input  ddtc_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ddtc_pkg::term_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [ddtc_pkg::SPEED_W-1:0] out_left,
  output logic signed [ddtc_pkg::SPEED_W-1:0] out_right,
  output logic                  out_done
);
  import ddtc_pkg::*;

  localparam int BASE_W = TERM_W + 1;
  localparam int MIX_W  = BASE_W + 1;

  logic                      adv;
  logic                      turn_pos;
  logic signed [BASE_W-1:0]  angle_ext;
  logic signed [BASE_W-1:0]  min_ext;
  logic signed [BASE_W-1:0]  base;
  logic signed [MIX_W-1:0]   base_ext;
  logic signed [MIX_W-1:0]   sync_ext;
  logic signed [MIX_W-1:0]   left_raw;
  logic signed [MIX_W-1:0]   right_raw;
  logic signed [SPEED_W-1:0] left_next;
  logic signed [SPEED_W-1:0] right_next;

  // Clamp to +-max_speed
  function automatic logic signed [SPEED_W-1:0] clamp_speed(
    input logic signed [MIX_W-1:0] x,
    input logic [LIMIT_W-1:0]      lim
  );
    logic signed [MIX_W-1:0] hi;
    hi = {{(MIX_W-LIMIT_W){1'b0}}, lim};
    if (x > hi) begin
      clamp_speed = SPEED_W'(hi);
    end else if (x < -hi) begin
      clamp_speed = SPEED_W'(-hi);
    end else begin
      clamp_speed = x[SPEED_W-1:0];
    end
  endfunction

  assign in_ready = out_ready || !out_valid;
  assign adv      = in_valid && in_ready;

  // Base speed in the turn direction, sync correction, clamp
  always_comb begin
    turn_pos  = !cfg.target_ticks[31] && (cfg.target_ticks != '0);
    angle_ext = {in_item.angle_term[TERM_W-1], in_item.angle_term};
    min_ext   = {{(BASE_W-LIMIT_W){1'b0}}, cfg.min_speed};
    base      = turn_pos ? (angle_ext + min_ext) : (angle_ext - min_ext);
    base_ext  = {base[BASE_W-1], base};
    sync_ext  = {{2{in_item.sync_term[TERM_W-1]}}, in_item.sync_term};
    left_raw  = base_ext - sync_ext;
    right_raw = -base_ext - sync_ext;
    if (in_item.flags.zero) begin
      left_next  = '0;
      right_next = '0;
    end else begin
      left_next  = clamp_speed(left_raw, cfg.max_speed);
      right_next = -clamp_speed(right_raw, cfg.max_speed);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_left  <= left_next;
      out_right <= right_next;
      out_done  <= in_item.flags.done;
    end
  end

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_done) |-> ((out_left == '0) && (out_right == '0)))
    else $error("done result with nonzero speed");

  a_no_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_left != {1'b1, {(SPEED_W-1){1'b0}}})
                   && (out_right != {1'b1, {(SPEED_W-1){1'b0}}})))
    else $error("speed outside symmetric range");

  a_stall_keep: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_left) && $stable(out_right)))
    else $error("stalled result lost or changed");

endmodule

@@ rtl/differential_drive_turn_controller.sv @@
// Proportional turn-in-place controller for a two-wheel drive, top level.
// Throughput: one request per cycle while the result side does not stall; a request passes
// the input register, the error register and the gain register into the result register,
// each handing over when the next is free.
// Reset (rst, synchronous): empties the pipeline, clears the start positions and
// loads register defaults (max_speed 32767, tolerance 100, all others zero).
`timescale 1ns / 1ps

module differential_drive_turn_controller #(
  parameter int POS_WIDTH = ddtc_pkg::POS_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_wr_en,
  input  logic [ddtc_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [ddtc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // request stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((2*POS_WIDTH+7)/8)*8-1:0]     s_tdata,  // left_position, right_position
  input  logic                                 s_tuser,  // mode
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [2*ddtc_pkg::SPEED_W-1:0]       m_tdata,  // left_speed, right_speed
  output logic                                 m_tuser   // done_res
);
  import ddtc_pkg::*;

  cfg_t       cfg;
  logic       err_valid;
  logic       err_ready;
  err_item_t  err_item;
  logic       term_valid;
  logic       term_ready;
  term_item_t term_item;
  logic signed [SPEED_W-1:0] left_speed;
  logic signed [SPEED_W-1:0] right_speed;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_ticks <= '0;
      cfg.angle_gain   <= '0;
      cfg.sync_gain    <= '0;
      cfg.min_speed    <= '0;
      cfg.max_speed    <= MAX_SPEED_RST;
      cfg.tolerance    <= TOLERANCE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_TARGET_TICKS: cfg.target_ticks <= cfg_wdata;
        REG_ANGLE_GAIN:   cfg.angle_gain   <= cfg_wdata[GAIN_W-1:0];
        REG_SYNC_GAIN:    cfg.sync_gain    <= cfg_wdata[GAIN_W-1:0];
        REG_MIN_SPEED:    cfg.min_speed    <= cfg_wdata[LIMIT_W-1:0];
        REG_MAX_SPEED:    cfg.max_speed    <= cfg_wdata[LIMIT_W-1:0];
        REG_TOLERANCE:    cfg.tolerance    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  ddtc_err #(
    .POS_WIDTH (POS_WIDTH)
  ) u_err (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_left   (s_tdata[POS_WIDTH-1:0]),
    .in_right  (s_tdata[2*POS_WIDTH-1:POS_WIDTH]),
    .out_valid (err_valid),
    .out_ready (err_ready),
    .out_item  (err_item)
  );

  ddtc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_item   (err_item),
    .out_valid (term_valid),
    .out_ready (term_ready),
    .out_item  (term_item)
  );

  ddtc_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (term_valid),
    .in_ready  (term_ready),
    .in_item   (term_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_left  (left_speed),
    .out_right (right_speed),
    .out_done  (m_tuser)
  );

  assign m_tdata = {right_speed, left_speed};

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the differential drive turn controller.
// Needs ddtc_pkg and differential_drive_turn_controller; a behavioral model of the
// controller predicts every result, which is checked in arrival order.
`timescale 1ns / 1ps

module tb;
  import ddtc_pkg::*;

  typedef struct packed {
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic                      done_res;
  } wheel_cmd_t;

  localparam int     LATENCY      = 3;
  localparam int     WATCHDOG_NS  = 400000;
  localparam int     REPORT_CAP   = 100;
  localparam longint SAT_BOUND    = longint'(SAT_LIM);
  localparam int     RANDOM_ITEMS = 125;
  localparam int     RANDOM_SETS  = 10;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_addr = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [63:0]             s_tdata = '0;       // left_position, right_position
  logic                    s_tuser = MODE_START; // mode
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [2*SPEED_W-1:0]    m_tdata;            // left_speed, right_speed
  logic                    m_tuser;            // done_res

  differential_drive_turn_controller uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Controller shadow: registers and latched start positions
  cfg_t               cfg_shadow;
  logic signed [31:0] left_origin;
  logic signed [31:0] right_origin;

  wheel_cmd_t  cmd_queue[$];
  int unsigned mismatch_count = 0;
  int unsigned checked_count = 0;
  int unsigned sent_count = 0;
  int unsigned finished_count = 0;
  int unsigned setting_count = 0;
  bit          jitter_on = 1'b1;
  int unsigned hold_cycles = 0;

  function automatic longint sat_range(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Q8.8 gain, truncated toward zero
  function automatic longint gain_scale(longint err, longint gain);
    longint mag;
    mag = (err < 0) ? -err : err;
    mag = (mag * gain) >>> 8;
    return (err < 0) ? -mag : mag;
  endfunction

  // Work out the wheel commands for one request and update the start positions
  function automatic wheel_cmd_t turn_command(logic mode, logic signed [31:0] lpos,
                                              logic signed [31:0] rpos);
    wheel_cmd_t         cmd;
    logic signed [31:0] wrapped;
    longint tgt, ag, sg, mins, maxs, tol;
    longint dl, dr, ea, es, at, ct, base, lcmd, rcmd;
    cmd  = '0;
    tgt  = $signed(cfg_shadow.target_ticks);
    ag   = cfg_shadow.angle_gain;
    sg   = cfg_shadow.sync_gain;
    mins = cfg_shadow.min_speed;
    maxs = cfg_shadow.max_speed;
    tol  = cfg_shadow.tolerance;
    cmd.done_res = (tgt == 0);
    if (mode == MODE_START) begin
      left_origin  = lpos;
      right_origin = rpos;
      return cmd;
    end
    if (tgt == 0) return cmd;
    // deltas wrap at the position width; right wheel is mirrored
    wrapped = lpos - left_origin;
    dl = sat_range(longint'(wrapped), SAT_BOUND);
    wrapped = rpos - right_origin;
    dr = sat_range(-longint'(wrapped), SAT_BOUND);
    ea = sat_range(tgt - (dl - dr), SAT_BOUND);
    es = sat_range(dl + dr, SAT_BOUND);
    if (((ea < 0) ? -ea : ea) < tol) begin
      cmd.done_res = 1'b1;
      return cmd;
    end
    at   = gain_scale(ea, ag);
    ct   = gain_scale(es, sg);
    base = (tgt > 0) ? (mins + at) : (at - mins);
    lcmd = sat_range(base - ct, maxs);
    rcmd = -sat_range(-base - ct, maxs);
    cmd.left_speed  = lcmd[15:0];
    cmd.right_speed = rcmd[15:0];
    return cmd;
  endfunction

  // Write one register; called and returns at a rising edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_TARGET_TICKS: cfg_shadow.target_ticks = value;
      REG_ANGLE_GAIN:   cfg_shadow.angle_gain   = value[GAIN_W-1:0];
      REG_SYNC_GAIN:    cfg_shadow.sync_gain    = value[GAIN_W-1:0];
      REG_MIN_SPEED:    cfg_shadow.min_speed    = value[LIMIT_W-1:0];
      REG_MAX_SPEED:    cfg_shadow.max_speed    = value[LIMIT_W-1:0];
      REG_TOLERANCE:    cfg_shadow.tolerance    = value[15:0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering requests and wait for every outstanding result
  task automatic await_results();
    s_tvalid <= 1'b0;
    while (cmd_queue.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    await_results();
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic apply_config(logic [31:0] tgt, logic [15:0] ag, logic [15:0] sg,
                              logic [14:0] mins, logic [14:0] maxs, logic [15:0] tol);
    settle();
    write_reg(REG_TARGET_TICKS, tgt);
    write_reg(REG_ANGLE_GAIN, 32'(ag));
    write_reg(REG_SYNC_GAIN, 32'(sg));
    write_reg(REG_MIN_SPEED, 32'(mins));
    write_reg(REG_MAX_SPEED, 32'(maxs));
    write_reg(REG_TOLERANCE, 32'(tol));
    setting_count++;
  endtask

  // Offer one request, hold it until accepted, then sometimes pause before returning
  task automatic send_item(logic mode, logic signed [31:0] lpos, logic signed [31:0] rpos);
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {rpos, lpos};
    do @(posedge clk); while (!s_tready);
    cmd_queue.push_back(turn_command(mode, lpos, rpos));
    sent_count++;
    if (jitter_on && $urandom_range(0, 99) < 11) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Result side readiness: long hold-off when requested, else random stalls
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      m_tready    <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_tready <= !(jitter_on && $urandom_range(0, 99) < 11);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    wheel_cmd_t want;
    wheel_cmd_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.left_speed  = m_tdata[SPEED_W-1:0];
      got.right_speed = m_tdata[2*SPEED_W-1:SPEED_W];
      got.done_res    = m_tuser;
      if (cmd_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
          $error("result with no request outstanding: left_speed %0d right_speed %0d",
                 got.left_speed, got.right_speed);
      end else begin
        want = cmd_queue.pop_front();
        checked_count++;
        if (want.done_res) finished_count++;
        if (got.left_speed !== want.left_speed) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $error("left_speed: expected %0d, got %0d", want.left_speed, got.left_speed);
        end
        if (got.right_speed !== want.right_speed) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $error("right_speed: expected %0d, got %0d", want.right_speed, got.right_speed);
        end
        if (got.done_res !== want.done_res) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
        end
      end
    end
  end

  // Defaults after reset: zero target, so every sample reports done
  task automatic test_reset_defaults();
    repeat (3) send_item(MODE_SAMPLE, $urandom, $urandom);
  endtask

  // Samples before any start request measure from the reset origin of zero
  task automatic test_unlatched_sample();
    apply_config(32'd1000, 16'd256, 16'd256, 15'd0, 15'd32767, 16'd100);
    send_item(MODE_SAMPLE, 32'sd300, -32'sd200);
    send_item(MODE_SAMPLE, 32'sd1000, 32'sd0);
    send_item(MODE_SAMPLE, -32'sd5000, 32'sd7000);
  endtask

  // Tolerance edges, wrapping deltas, extreme registers and positions
  task automatic test_directed();
    apply_config(32'd1000, 16'd256, 16'd128, 15'd50, 15'd2000, 16'd100);
    send_item(MODE_START, 32'sd0, 32'sd0);
    send_item(MODE_SAMPLE, 32'sd0, 32'sd0);
    send_item(MODE_SAMPLE, 32'sd500, 32'sd500);
    send_item(MODE_SAMPLE, 32'sd950, 32'sd0);
    send_item(MODE_SAMPLE, 32'sd900, 32'sd0);
    send_item(MODE_SAMPLE, 32'sd901, 32'sd0);
    send_item(MODE_SAMPLE, 32'sd1100, 32'sd0);
    send_item(MODE_SAMPLE, 32'sd400, -32'sd400);
    send_item(MODE_START, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(MODE_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(MODE_START, 32'sd0, 32'sd0);
    send_item(MODE_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(MODE_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF);
    // most negative target, full gains and speeds, zero tolerance
    apply_config(32'h8000_0000, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 16'd0);
    send_item(MODE_SAMPLE, 32'h8000_0000, 32'h8000_0000);
    send_item(MODE_SAMPLE, 32'hFFFF_FFFF, 32'sd0);
    send_item(MODE_SAMPLE, 32'sd0, 32'hFFFF_FFFF);
    // most positive target with a zero speed clamp and widest tolerance
    apply_config(32'h7FFF_FFFF, 16'd1, 16'd0, 15'd0, 15'd0, 16'hFFFF);
    send_item(MODE_SAMPLE, 32'sd0, 32'sd0);
    send_item(MODE_SAMPLE, 32'h7FFF_FF00, 32'sd0);
    // zero target: start request reports done
    apply_config(32'd0, 16'd300, 16'd300, 15'd10, 15'd500, 16'd100);
    send_item(MODE_START, $urandom, $urandom);
    send_item(MODE_SAMPLE, $urandom, $urandom);
  endtask

  // Hold off the result side until the block fills; then a sender pause
  task automatic test_backpressure();
    apply_config(-32'sd3000, 16'd384, 16'd200, 15'd100, 15'd8000, 16'd50);
    jitter_on = 1'b0;
    send_item(MODE_START, $urandom, $urandom);
    hold_cycles <= 300;
    repeat (40)
      send_item(MODE_SAMPLE, left_origin + $signed($urandom_range(0, 4000)) - 2000,
                right_origin + $signed($urandom_range(0, 4000)) - 2000);
    jitter_on = 1'b1;
    repeat (20) send_item(MODE_SAMPLE, $urandom, $urandom);
    await_results();
    repeat (20) send_item(MODE_SAMPLE, $urandom, $urandom);
    settle();
  endtask

  // Random settings; mostly start-then-approach turns, some noise requests
  task automatic test_random();
    logic [31:0]        tgt;
    logic [15:0]        ag, sg, tol;
    logic [14:0]        mins, maxs;
    logic signed [31:0] lo, ro;
    longint             span, slack, goal, angle, dl, dr;
    int                 count, steps;
    for (int set = 0; set < RANDOM_SETS; set++) begin
      case ($urandom_range(0, 5))
        0: tgt = $urandom;
        1: tgt = 32'd0;
        2: tgt = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        3: tgt = 32'($signed($urandom_range(0, 400000)) - 200000);
        default: tgt = 32'($signed($urandom_range(0, 8000)) - 4000);
      endcase
      ag   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
      sg   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
      mins = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 600));
      maxs = ($urandom_range(0, 3) == 0) ? 15'h7FFF : 15'($urandom);
      tol  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
      apply_config(tgt, ag, sg, mins, maxs, tol);
      jitter_on = (set != RANDOM_SETS / 2);
      span  = $signed(tgt);
      slack = longint'(tol) + 20;
      count = 0;
      while (count < RANDOM_ITEMS) begin
        if ($urandom_range(0, 99) < 12) begin
          send_item(1'($urandom_range(0, 1)), $urandom, $urandom);
          count++;
        end else begin
          lo = $urandom;
          ro = $urandom;
          send_item(MODE_START, lo, ro);
          steps = $urandom_range(3, 15);
          count++;
          // approach the target, landing near the tolerance band
          for (int k = 1; k <= steps; k++) begin
            goal  = (span * k) / steps;
            angle = goal + longint'($urandom_range(0, 2 * slack)) - slack;
            dl    = angle / 2 + longint'($urandom_range(0, 200)) - 100;
            dr    = dl - angle;
            send_item(MODE_SAMPLE, lo + 32'(dl), ro - 32'(dr));
            count++;
          end
        end
      end
    end
    jitter_on = 1'b1;
  endtask

  initial begin
    cfg_shadow.target_ticks = '0;
    cfg_shadow.angle_gain   = '0;
    cfg_shadow.sync_gain    = '0;
    cfg_shadow.min_speed    = '0;
    cfg_shadow.max_speed    = MAX_SPEED_RST;
    cfg_shadow.tolerance    = TOLERANCE_RST;
    left_origin  = '0;
    right_origin = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_unlatched_sample();
    test_directed();
    test_backpressure();
    test_random();
    settle();
    $display("run covered %0d requests over %0d register settings, incl. a long output stall",
             sent_count, setting_count);
    $display("%0d results compared, %0d of them finished turns, %0d mismatches",
             checked_count, finished_count, mismatch_count);
    if (mismatch_count == 0 && cmd_queue.size() == 0) begin
      $display("differential_drive_turn_controller: match");
    end else begin
      $display("differential_drive_turn_controller: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(WATCHDOG_NS);
    $display("differential_drive_turn_controller: mismatch");
    $finish;
  end

endmodule
